/* src/arpc_pkg.sv */
package arpc_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int TICK_W = 16;
   localparam int REQ_W  = 2;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd15;

   // request codes, the fourth code is unused and changes nothing
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [TICK_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] mac_found;
      logic             stored;
   } res_type;

endpackage

/* src/arpc_req_if.sv */
interface arpc_req_if;
   import arpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [IP_W-1:0]  ip_addr;
   logic [MAC_W-1:0] mac_addr;

   modport source (output valid, output req_type, output ip_addr, output mac_addr,
                   input ready);
   modport sink (input valid, input req_type, input ip_addr, input mac_addr,
                 output ready);
endinterface

/* src/arpc_rsp_if.sv */
interface arpc_rsp_if;
   import arpc_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [MAC_W-1:0] mac_found;
   logic             stored;

   modport source (output valid, output hit, output mac_found, output stored,
                   input ready);
   modport sink (input valid, input hit, input mac_found, input stored,
                 output ready);
endinterface

/* src/arpc_table_mem.sv */
module arpc_table_mem #(
   parameter int DEPTH = arpc_pkg::TABLE_ENTRIES_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output arpc_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  arpc_pkg::entry_type wr_data
);
   import arpc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/arpc_scan_ctrl.sv */
module arpc_scan_ctrl #(
   parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
   parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   arpc_req_if.sink                    req,
   input  logic [arpc_pkg::TICK_W-1:0] timeout,
   output logic                        res_valid,
   output arpc_pkg::res_type           res,
   input  logic                        res_take,
   output logic                        mem_rd_en,
   output logic [IDX_W-1:0]            mem_rd_addr,
   input  arpc_pkg::entry_type         mem_rd_data,
   output logic                        mem_wr_en,
   output logic [IDX_W-1:0]            mem_wr_addr,
   output arpc_pkg::entry_type         mem_wr_data
);
   import arpc_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_LAST  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [REQ_W-1:0]  op_ff, op_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic              hit_ff, hit_in;
   logic [MAC_W-1:0]  macf_ff, macf_in;
   logic              stored_ff, stored_in;
   logic [TICK_W-1:0] age;

   assign age = now_ff - mem_rd_data.stamp;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pidx_in     = cnt_ff[IDX_W-1:0];
      now_in      = now_ff;
      op_in       = op_ff;
      ip_in       = ip_ff;
      mac_in      = mac_ff;
      hit_in      = hit_ff;
      macf_in     = macf_ff;
      stored_in   = stored_ff;
      req.ready   = 1'b0;
      res_valid   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = pidx_ff;
      mem_wr_data = mem_rd_data;

      // entry read in the previous cycle is checked and written back here
      if (pend_ff) begin
         case (op_ff)
            REQ_LOOKUP: begin
               if (mem_rd_data.valid && mem_rd_data.ip == ip_ff) begin
                  hit_in  = 1'b1;
                  macf_in = mem_rd_data.mac;
               end
            end
            REQ_INSERT: begin
               if (!mem_rd_data.valid && !stored_ff) begin
                  stored_in         = 1'b1;
                  mem_wr_en         = 1'b1;
                  mem_wr_data.valid = 1'b1;
                  mem_wr_data.ip    = ip_ff;
                  mem_wr_data.mac   = mac_ff;
                  mem_wr_data.stamp = now_ff;
               end
            end
            REQ_TICK: begin
               if (mem_rd_data.valid && age > timeout) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_data.valid = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[IDX_W-1:0];
            mem_wr_data = '0;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in     = req.req_type;
               ip_in     = req.ip_addr;
               mac_in    = req.mac_addr;
               hit_in    = 1'b0;
               macf_in   = '0;
               stored_in = 1'b0;
               cnt_in    = '0;
               if (req.req_type == REQ_TICK) begin
                  now_in = now_ff + 1'b1;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
            pend_in   = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.hit       = hit_ff;
   assign res.mac_found = macf_ff;
   assign res.stored    = stored_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         now_ff   <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff   <= pidx_in;
      op_ff     <= op_in;
      ip_ff     <= ip_in;
      mac_ff    <= mac_in;
      hit_ff    <= hit_in;
      macf_ff   <= macf_in;
      stored_ff <= stored_in;
   end

endmodule

/* src/arp_cache_table_with_aging.sv */
// channel  direction  contents
// req      in         req_type, ip_addr, mac_addr
// rsp      out        hit, mac_found, stored
// csr      in         timeout_ticks write (csr_wr_en, csr_wr_data)
//
// every request scans the whole table, one entry per cycle through the read port
// of the table memory; the next req is taken after the scan, last, done states.
// after reset a clearing pass writes every entry invalid, during which req.ready
// stays low. reset is synchronous, active high. a result waits in the rsp
// register; a stalled rsp holds the scan of the next request only when that one
// is done and the register is still full.
module arp_cache_table_with_aging #(
   parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   arpc_req_if.sink                    req,
   arpc_rsp_if.source                  rsp,
   input  logic                        csr_wr_en,
   input  logic [arpc_pkg::TICK_W-1:0] csr_wr_data
);
   import arpc_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [TICK_W-1:0] timeout_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_data_ff;

   logic              res_valid;
   res_type           res;
   logic              res_take;

   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   entry_type         mem_rd_data;
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   entry_type         mem_wr_data;

   arpc_scan_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .timeout     (timeout_ff),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   arpc_table_mem #(
      .DEPTH (TABLE_ENTRIES),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // output register is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_data_ff.hit;
   assign rsp.mac_found = rsp_data_ff.mac_found;
   assign rsp.stored    = rsp_data_ff.stored;

endmodule
